// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, operation and status codes, and controller commands for the
// byte-wide double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;    // input beat taken, run the operation
    logic load_out;  // move pending result into the output register
  } cmd_t;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

endpackage

`default_nettype wire

// ----- design/deq_if.sv -----
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// Valid/ready channels for operations going in and results coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface deq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [1:0] status;
  logic [4:0] fill_level;

  modport source (output valid, output data_out, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input data_out, input status, input fill_level,
                  output ready);
endinterface

`default_nettype wire

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Byte-wide double-ended queue on a ring of DEPTH slots; push and pop at
// either end, one result beat per operation beat.
// ----------------------------------------------------------------------------
//   channel  | dir | payload                          | handshake
//   in_ch    | in  | operation[1:0], data_in[7:0]     | valid/ready
//   out_ch   | out | data_out[7:0], status[1:0],      | valid/ready
//            |     | fill_level[4:0]                  |
//
// an operation is accepted in idle, which registers the store read, and its
// result is loaded in exec; no new operation is accepted before that load.
// the output register lets the next operation be accepted while a result
// waits; a result stalled on out_ch holds the controller in its exec state.
// synchronous reset empties the queue; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);
  import deq_pkg::*;

  cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (in_ch.operation),
    .data_in    (in_ch.data_in),
    .data_out   (out_ch.data_out),
    .status     (out_ch.status),
    .fill_level (out_ch.fill_level)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.load_out))
    else $error("accept and output load in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ch.ready)
    else $error("input ready right after an accepted beat");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_ch.valid)
    else $error("loaded result not presented");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != ST_DONE) |-> (out_ch.data_out == '0))
    else $error("failed operation carries nonzero data");

endmodule

`default_nettype wire

// ----- design/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: takes one operation, waits for the store read, then hands the
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  output deq_pkg::cmd_t      cmd
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready     = (state == S_IDLE);
  assign out_free     = !out_valid || out_ready;
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.load_out = (state == S_EXEC) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/deq_dp.sv -----
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring store, front and back indices, fill count and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire deq_pkg::cmd_t                    cmd,
  input  wire logic [deq_pkg::OP_W-1:0]         operation,
  input  wire logic [deq_pkg::DATA_W-1:0]       data_in,
  output logic      [deq_pkg::DATA_W-1:0]       data_out,
  output logic      [deq_pkg::STATUS_W-1:0]     status,
  output logic      [deq_pkg::FILL_W-1:0]       fill_level
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [AW-1:0] front_index;
  logic [AW-1:0] back_index;
  logic [CW-1:0] fill_count;
  logic [AW-1:0] front_index_next;
  logic [AW-1:0] back_index_next;
  logic [CW-1:0] fill_count_next;

  logic          is_full;
  logic          is_empty;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  status_t       status_calc;
  logic          pop_calc;

  // result held between accept and output load
  status_t       pend_status;
  logic          pend_pop;
  logic [CW-1:0] pend_fill;

  assign is_full  = (fill_count == CW'(DEPTH));
  assign is_empty = (fill_count == '0);

  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    fill_count_next  = fill_count;
    mem_we           = 1'b0;
    waddr            = back_index;
    raddr            = front_index;
    status_calc      = ST_DONE;
    pop_calc         = 1'b0;
    case (op_t'(operation))
      OP_PUSH_FRONT: begin
        waddr = ring_dec(front_index);
        if (is_full) begin
          status_calc = ST_FULL;
        end else begin
          mem_we           = 1'b1;
          front_index_next = waddr;
          fill_count_next  = fill_count + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_calc = ST_FULL;
        end else begin
          mem_we          = 1'b1;
          back_index_next = ring_inc(back_index);
          fill_count_next = fill_count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_calc = ST_EMPTY;
        end else begin
          pop_calc         = 1'b1;
          front_index_next = ring_inc(front_index);
          fill_count_next  = fill_count - CW'(1);
        end
      end
      default: begin
        raddr = ring_dec(back_index);
        if (is_empty) begin
          status_calc = ST_EMPTY;
        end else begin
          pop_calc        = 1'b1;
          back_index_next = raddr;
          fill_count_next = fill_count - CW'(1);
        end
      end
    endcase
  end

  // read data is held until the result is loaded, however long out_ch stalls
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) mem[waddr] <= data_in;
    if (cmd.accept) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      fill_count  <= '0;
    end else if (cmd.accept) begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      fill_count  <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status <= status_calc;
      pend_pop    <= pop_calc;
      pend_fill   <= fill_count_next;
    end
    if (cmd.load_out) begin
      data_out   <= pend_pop ? rdata : '0;
      status     <= pend_status;
      fill_level <= FILL_W'(pend_fill);
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/double_ended_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives push/pop operations at both ends of the byte deque, first from a
// directed table (empty pops, extreme bytes, fill to full, rejected pushes),
// then in random fill, drain and mixed stretches. Every result beat is
// checked field by field against an in-order queue of predicted results.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  import deq_pkg::*;

  localparam int RANDOM_OPS = 1050;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_ROWS     = 25;

  typedef struct {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } deq_result_t;

  typedef struct {
    op_t               op;
    logic [DATA_W-1:0] data;
    bit                typed;
    deq_result_t       want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted deque contents
  logic [DATA_W-1:0] ring_bytes [DEPTH];
  int                head_slot;
  int                tail_slot;
  int                stored_bytes;

  deq_result_t awaited_results [$];
  int          mismatches;
  int          idle_cycles;
  bit          sender_steady;

  op_row_t op_table [N_ROWS] = '{
    '{OP_POP_FRONT,  8'h00, 1'b1, '{8'h00, ST_EMPTY, 5'd0}},
    '{OP_POP_BACK,   8'hFF, 1'b1, '{8'h00, ST_EMPTY, 5'd0}},
    '{OP_PUSH_BACK,  8'h00, 1'b1, '{8'h00, ST_DONE,  5'd1}},
    '{OP_PUSH_FRONT, 8'hFF, 1'b1, '{8'h00, ST_DONE,  5'd2}},
    '{OP_POP_BACK,   8'h00, 1'b1, '{8'h00, ST_DONE,  5'd1}},
    '{OP_POP_FRONT,  8'h00, 1'b1, '{8'hFF, ST_DONE,  5'd0}},
    '{OP_POP_FRONT,  8'hFF, 1'b1, '{8'h00, ST_EMPTY, 5'd0}},
    '{OP_PUSH_FRONT, 8'h01, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'h02, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'h04, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'h08, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'h10, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'h20, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'h40, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'h80, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'hFE, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'hFD, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'hFB, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'hF7, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'hEF, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'hDF, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'hBF, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_BACK,  8'h7F, 1'b0, '{8'h00, ST_DONE,  5'd0}},
    '{OP_PUSH_FRONT, 8'hA5, 1'b1, '{8'h00, ST_FULL,  5'd16}},
    '{OP_PUSH_BACK,  8'h5A, 1'b1, '{8'h00, ST_FULL,  5'd16}}
  };

  function automatic int step_slot(int slot, int delta);
    return (slot + delta + DEPTH) % DEPTH;
  endfunction

  function automatic deq_result_t apply_deque_op(op_t op, logic [DATA_W-1:0] din);
    deq_result_t r;
    r = '{8'h00, ST_DONE, 5'd0};
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (stored_bytes >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_slot = step_slot(head_slot, -1);
            ring_bytes[head_slot] = din;
          end else begin
            ring_bytes[tail_slot] = din;
            tail_slot = step_slot(tail_slot, 1);
          end
          stored_bytes++;
        end
      end
      default: begin
        if (stored_bytes == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            r.data = ring_bytes[head_slot];
            head_slot = step_slot(head_slot, 1);
          end else begin
            tail_slot = step_slot(tail_slot, -1);
            r.data = ring_bytes[tail_slot];
          end
          stored_bytes--;
        end
      end
    endcase
    r.fill = FILL_W'(stored_bytes);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // entered and left at a falling edge
  task automatic drive_op(op_t op, logic [DATA_W-1:0] din, bit typed, deq_result_t want);
    int          gap;
    deq_result_t predicted;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_in   <= din;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_deque_op(op, din);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // result beat checker
  always @(posedge clk) begin : result_check
    deq_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: data %0d status %0d fill %0d",
                                out_ch.data_out, out_ch.status, out_ch.fill_level));
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.data_out !== want.data)
          flag_mismatch($sformatf("data_out expected %0d got %0d", want.data, out_ch.data_out));
        if (out_ch.status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d", want.status, out_ch.status));
        if (out_ch.fill_level !== want.fill)
          flag_mismatch($sformatf("fill_level expected %0d got %0d", want.fill,
                                  out_ch.fill_level));
      end
    end
  end

  // no beat on either side for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin : result_stall
    int stall_left;
    int stretch_left;
    bit steady;
    stall_left   = 0;
    stretch_left = 0;
    steady       = 1'b0;
    out_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stretch_left == 0) begin
        steady       = ($urandom_range(0, 4) == 0);
        stretch_left = $urandom_range(20, 120);
      end
      stretch_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(steady);
      end
    end
  end

  initial begin : stimulus
    int          sent;
    int          run_len;
    int          push_pct;
    int          run_count;
    op_t         op;
    deq_result_t none;
    none            = '{8'h00, ST_DONE, 5'd0};
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_PUSH_FRONT;
    in_ch.data_in   = 8'h00;
    head_slot       = 0;
    tail_slot       = 0;
    stored_bytes    = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    sender_steady   = 1'b0;
    foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (op_table[i])
      drive_op(op_table[i].op, op_table[i].data, op_table[i].typed, op_table[i].want);
    hold_until_drained();

    // random stretches leaning toward fill, drain or neither
    sent      = 0;
    run_count = 0;
    while (sent < RANDOM_OPS) begin
      run_len       = $urandom_range(10, 60);
      sender_steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      repeat (run_len) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        drive_op(op, 8'($urandom_range(0, 255)), 1'b0, none);
        sent++;
      end
      run_count++;
      if (run_count % 5 == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
design/deq_pkg.sv
design/deq_if.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue.sv
tb/sv/double_ended_queue_test.sv
